### sv/sensor_link_sync_and_frame_receiver_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the sensor link receiver, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_LINK_SYNC_AND_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SENSOR_LINK_SYNC_AND_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define SLSFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/slsfr_pkg.sv
// ----------------------------------------------------------------------------
// slsfr_pkg
// Types, codes and constants of the sensor link sync and frame receiver.
// ----------------------------------------------------------------------------
package slsfr_pkg;

	localparam logic [3:0] SYNC_TOKEN_LEN = 4'd10;
	localparam int unsigned WORD_BYTES = 4;
	localparam int unsigned TDATA_OUT_W = 104;

	localparam logic [7:0] HASH_CHAR = 8'h23;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_FLUSH,
		PH_HUNT,
		PH_STREAM,
		PH_FAILED,
		PH_STOPPED
	} phase_t;

	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	localparam logic [1:0] EV_CMD = 2'd0;
	localparam logic [1:0] EV_SYNC_OK = 2'd1;
	localparam logic [1:0] EV_SYNC_FAIL = 2'd2;
	localparam logic [1:0] EV_FRAME = 2'd3;

	localparam logic [1:0] CMD_CONT = 2'd0;
	localparam logic [1:0] CMD_BINARY = 2'd1;
	localparam logic [1:0] CMD_SYNC = 2'd2;
	localparam logic [1:0] CMD_TEXT = 2'd3;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RESEND = 2'd1;
	localparam logic [1:0] REG_SETTLE = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] hunt_timeout_ms;
		logic [15:0] resend_interval_ms;
		logic [15:0] settle_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [1:0] command;
	} tag_t;

	// results of one item: up to three tags, words shared (frames come alone)
	typedef struct packed {
		logic [1:0]  count;
		tag_t [2:0]  tags;
		logic [31:0] yaw_bits;
		logic [31:0] pitch_bits;
		logic [31:0] roll_bits;
	} bundle_t;

	function automatic logic [7:0] sync_ref(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h23;
			4'd1: c = 8'h53;
			4'd2: c = 8'h59;
			4'd3: c = 8'h4e;
			4'd4: c = 8'h43;
			4'd5: c = 8'h48;
			4'd6: c = 8'h30;
			4'd7: c = 8'h30;
			4'd8: c = 8'h0d;
			4'd9: c = 8'h0a;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### sv/slsfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// slsfr_cfg_regs
// Configuration register file: timeout, resend interval and settle delay.
// ----------------------------------------------------------------------------
module slsfr_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output slsfr_pkg::cfg_t    cfg
);

	slsfr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hunt_timeout_ms <= 16'd1000;
			cfg_q.resend_interval_ms <= 16'd200;
			cfg_q.settle_ms <= 16'd200;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				slsfr_pkg::REG_TIMEOUT: cfg_q.hunt_timeout_ms <= cfg_data;
				slsfr_pkg::REG_RESEND:  cfg_q.resend_interval_ms <= cfg_data;
				slsfr_pkg::REG_SETTLE:  cfg_q.settle_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### sv/slsfr_in_reg.sv
// ----------------------------------------------------------------------------
// slsfr_in_reg
// Input beat register; refills in the cycle its content is consumed.
// ----------------------------------------------------------------------------
module slsfr_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              take,
	output logic              valid_s1,
	output slsfr_pkg::item_t  item_s1
);

	logic             valid_q;
	slsfr_pkg::item_t item_q;

	assign s_tready = !valid_q || take;
	assign valid_s1 = valid_q;
	assign item_s1 = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.mode <= s_tuser;
			item_q.rx_byte <= s_tdata;
		end
	end

endmodule

### sv/slsfr_core.sv
// ----------------------------------------------------------------------------
// slsfr_core
// Link state: start-up, flush, sync hunt with timers, word and frame packing
// and stop. Produces the result bundle of the item in the input register.
// ----------------------------------------------------------------------------
`include "sensor_link_sync_and_frame_receiver_unit_macros.svh"

module slsfr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  slsfr_pkg::item_t    item_s1,
	input  slsfr_pkg::cfg_t     cfg,
	output slsfr_pkg::bundle_t  bundle
);

	slsfr_pkg::phase_t phase_q, phase_d;
	logic [3:0]  token_index_q, token_index_d;
	logic        token_mismatch_q, token_mismatch_d;
	logic [1:0]  byte_in_word_q, byte_in_word_d;
	logic [1:0]  word_in_frame_q, word_in_frame_d;
	logic [31:0] word_assembly_q, word_assembly_d;
	logic [31:0] held_q [2];
	logic [31:0] held0_d, held1_d;
	logic [15:0] since_start_q, since_start_d;
	logic [15:0] since_request_q, since_request_d;
	logic [15:0] settle_left_q, settle_left_d;

	logic        is_byte, is_tick, is_stop, is_newline, is_hash;
	logic [3:0]  token_next;
	logic        token_done, token_bad, sync_ok, counting;
	logic        resend_hit, timeout_hit, word_done;
	logic [31:0] word_full;
	logic [1:0]  n;
	slsfr_pkg::bundle_t b_d;

	assign is_byte = item_s1.mode == slsfr_pkg::MODE_BYTE;
	assign is_tick = item_s1.mode == slsfr_pkg::MODE_TICK;
	assign is_stop = item_s1.mode == slsfr_pkg::MODE_STOP;
	assign is_newline = item_s1.rx_byte == slsfr_pkg::NEWLINE_CHAR;
	assign is_hash = item_s1.rx_byte == slsfr_pkg::HASH_CHAR;
	assign token_next = token_index_q + 4'd1;
	assign token_done = token_next >= slsfr_pkg::SYNC_TOKEN_LEN;
	assign token_bad = token_mismatch_q ||
		(item_s1.rx_byte != slsfr_pkg::sync_ref(token_index_q));
	assign sync_ok = token_done && !token_bad;
	assign counting = is_tick && (phase_q == slsfr_pkg::PH_HUNT) &&
		(token_index_q == 4'd0) && (settle_left_q == 16'd0);
	assign resend_hit = since_request_q >= cfg.resend_interval_ms;
	assign timeout_hit = since_start_q >= cfg.hunt_timeout_ms;
	assign word_done = byte_in_word_q == 2'd3;
	assign word_full = word_assembly_q |
		({24'd0, item_s1.rx_byte} << {byte_in_word_q, 3'b000});
	assign bundle = b_d;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			slsfr_pkg::PH_WAIT: begin
				if (is_byte) begin
					phase_d = is_newline ? slsfr_pkg::PH_HUNT : slsfr_pkg::PH_FLUSH;
				end
			end
			slsfr_pkg::PH_FLUSH: begin
				if (is_byte && is_newline) begin
					phase_d = slsfr_pkg::PH_HUNT;
				end
			end
			slsfr_pkg::PH_HUNT: begin
				if (is_byte && (token_index_q != 4'd0) && sync_ok) begin
					phase_d = slsfr_pkg::PH_STREAM;
				end else if (counting && timeout_hit) begin
					phase_d = slsfr_pkg::PH_FAILED;
				end
			end
			slsfr_pkg::PH_STREAM: begin
				if (is_stop) begin
					phase_d = slsfr_pkg::PH_STOPPED;
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// results and datapath state
	always_comb begin
		b_d = '0;
		n = 2'd0;
		token_index_d = token_index_q;
		token_mismatch_d = token_mismatch_q;
		byte_in_word_d = byte_in_word_q;
		word_in_frame_d = word_in_frame_q;
		word_assembly_d = word_assembly_q;
		held0_d = held_q[0];
		held1_d = held_q[1];
		since_start_d = since_start_q;
		since_request_d = since_request_q;
		settle_left_d = settle_left_q;
		case (phase_q)
			slsfr_pkg::PH_WAIT, slsfr_pkg::PH_FLUSH: begin
				if (is_byte && phase_q == slsfr_pkg::PH_WAIT) begin
					b_d.tags[n] = '{slsfr_pkg::EV_CMD, slsfr_pkg::CMD_CONT};
					n = n + 2'd1;
					b_d.tags[n] = '{slsfr_pkg::EV_CMD, slsfr_pkg::CMD_BINARY};
					n = n + 2'd1;
				end
				if (is_byte && is_newline) begin
					b_d.tags[n] = '{slsfr_pkg::EV_CMD, slsfr_pkg::CMD_SYNC};
					n = n + 2'd1;
					settle_left_d = cfg.settle_ms;
					since_start_d = 16'd0;
					since_request_d = 16'd0;
					token_index_d = 4'd0;
					token_mismatch_d = 1'b0;
				end
			end
			slsfr_pkg::PH_HUNT: begin
				if (is_byte) begin
					if (token_index_q == 4'd0) begin
						if (is_hash) begin
							token_index_d = 4'd1;
							token_mismatch_d = slsfr_pkg::sync_ref(4'd0) != slsfr_pkg::HASH_CHAR;
						end
					end else if (token_done) begin
						if (!token_bad) begin
							b_d.tags[n] = '{slsfr_pkg::EV_SYNC_OK, slsfr_pkg::CMD_CONT};
							n = n + 2'd1;
							b_d.tags[n] = '{slsfr_pkg::EV_CMD, slsfr_pkg::CMD_BINARY};
							n = n + 2'd1;
							byte_in_word_d = 2'd0;
							word_in_frame_d = 2'd0;
							word_assembly_d = 32'd0;
						end
						token_index_d = 4'd0;
						token_mismatch_d = 1'b0;
					end else begin
						token_index_d = token_next;
						token_mismatch_d = token_bad;
					end
				end
				if (is_tick && token_index_q == 4'd0) begin
					if (settle_left_q != 16'd0) begin
						settle_left_d = settle_left_q - 16'd1;
					end else begin
						if (resend_hit) begin
							b_d.tags[n] = '{slsfr_pkg::EV_CMD, slsfr_pkg::CMD_SYNC};
							n = n + 2'd1;
							since_request_d = 16'd0;
						end else begin
							since_request_d = since_request_q + 16'd1;
						end
						if (timeout_hit) begin
							b_d.tags[n] = '{slsfr_pkg::EV_SYNC_FAIL, slsfr_pkg::CMD_CONT};
							n = n + 2'd1;
						end else begin
							since_start_d = since_start_q + 16'd1;
						end
					end
				end
			end
			slsfr_pkg::PH_STREAM: begin
				if (is_byte) begin
					if (word_done) begin
						byte_in_word_d = 2'd0;
						word_assembly_d = 32'd0;
						if (word_in_frame_q != 2'd2) begin
							if (word_in_frame_q[0]) begin
								held1_d = word_full;
							end else begin
								held0_d = word_full;
							end
							word_in_frame_d = word_in_frame_q + 2'd1;
						end else begin
							b_d.tags[n] = '{slsfr_pkg::EV_FRAME, slsfr_pkg::CMD_CONT};
							n = n + 2'd1;
							b_d.yaw_bits = held_q[0];
							b_d.pitch_bits = held_q[1];
							b_d.roll_bits = word_full;
							word_in_frame_d = 2'd0;
						end
					end else begin
						word_assembly_d = word_full;
						byte_in_word_d = byte_in_word_q + 2'd1;
					end
				end
				if (is_stop) begin
					b_d.tags[n] = '{slsfr_pkg::EV_CMD, slsfr_pkg::CMD_TEXT};
					n = n + 2'd1;
				end
			end
			default: ;
		endcase
		b_d.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slsfr_pkg::PH_WAIT;
			token_index_q <= 4'd0;
			token_mismatch_q <= 1'b0;
			byte_in_word_q <= 2'd0;
			word_in_frame_q <= 2'd0;
			word_assembly_q <= 32'd0;
			since_start_q <= 16'd0;
			since_request_q <= 16'd0;
			settle_left_q <= 16'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			token_index_q <= token_index_d;
			token_mismatch_q <= token_mismatch_d;
			byte_in_word_q <= byte_in_word_d;
			word_in_frame_q <= word_in_frame_d;
			word_assembly_q <= word_assembly_d;
			since_start_q <= since_start_d;
			since_request_q <= since_request_d;
			settle_left_q <= settle_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_q[0] <= held0_d;
			held_q[1] <= held1_d;
		end
	end

	`SLSFR_ASSERT_NOW(a_token_range, 1'b1, token_index_q < slsfr_pkg::SYNC_TOKEN_LEN, "token index out of range")
	`SLSFR_ASSERT_NOW(a_frame_words, 1'b1, word_in_frame_q != 2'd3, "word count past frame")
	`SLSFR_ASSERT_NEXT(a_failed_sticks, phase_q == slsfr_pkg::PH_FAILED, phase_q == slsfr_pkg::PH_FAILED, "left failed phase")
	`SLSFR_ASSERT_NEXT(a_stopped_sticks, phase_q == slsfr_pkg::PH_STOPPED, phase_q == slsfr_pkg::PH_STOPPED, "left stopped phase")

endmodule

### sv/slsfr_out_ser.sv
// ----------------------------------------------------------------------------
// slsfr_out_ser
// Result register: holds one item's bundle and hands its results out one beat
// at a time, tlast on the final one.
// ----------------------------------------------------------------------------
`include "sensor_link_sync_and_frame_receiver_unit_macros.svh"

module slsfr_out_ser (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load,
	input  slsfr_pkg::bundle_t                       bundle,
	output logic                                     load_ok,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [slsfr_pkg::TDATA_OUT_W-1:0]        m_tdata,
	output logic [1:0]                               m_tuser,
	output logic                                     m_tlast
);

	slsfr_pkg::bundle_t bundle_q;
	logic [1:0]         idx_q;
	logic               busy_q;
	slsfr_pkg::tag_t    cur;

	assign cur = bundle_q.tags[idx_q];
	assign m_tvalid = busy_q;
	assign m_tlast = idx_q == (bundle_q.count - 2'd1);
	assign m_tuser = cur.event_res;
	assign m_tdata = {6'd0, bundle_q.roll_bits, bundle_q.pitch_bits, bundle_q.yaw_bits,
		cur.command};
	assign load_ok = !busy_q || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			busy_q <= bundle.count != 2'd0;
			idx_q <= 2'd0;
		end else if (busy_q && m_tready) begin
			if (m_tlast) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

	`SLSFR_ASSERT_NOW(a_busy_nonempty, busy_q, bundle_q.count != 2'd0, "empty bundle held")
	`SLSFR_ASSERT_NOW(a_idx_in_bundle, busy_q, idx_q < bundle_q.count, "index past bundle")
	`SLSFR_ASSERT_NOW(a_frame_alone, m_tvalid && m_tuser == slsfr_pkg::EV_FRAME, m_tlast, "frame not last")
	`SLSFR_ASSERT_NOW(a_sync_then_cmd, m_tvalid && m_tuser == slsfr_pkg::EV_SYNC_OK, !m_tlast, "sync without binary command")

endmodule

### sv/sensor_link_sync_and_frame_receiver_unit.sv
// Receives beats from a sensor link: bytes, millisecond ticks and a host stop,
// told apart by s_tuser. Each beat passes an input register and is worked by
// the core into the result register. A beat that gives at most one result
// leaves the result register free for the next, so one beat per cycle is
// sustained while m_tready is high; a beat that gives more results (at most
// three) holds the result register until they drain, and the input waits.
// No start-up sweep: the block takes beats right after reset.
// ----------------------------------------------------------------------------
// sensor_link_sync_and_frame_receiver_unit
// Top level: config registers, input register, link core and result output.
// ----------------------------------------------------------------------------
module sensor_link_sync_and_frame_receiver_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] rx_byte
	input  logic [1:0]    s_tuser,   // [1:0] mode
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [103:0]  m_tdata,   // [1:0] command, [33:2] yaw_bits,
	                                 // [65:34] pitch_bits, [97:66] roll_bits
	output logic [1:0]    m_tuser,   // [1:0] event_res
	output logic          m_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	slsfr_pkg::cfg_t    cfg;
	slsfr_pkg::item_t   item_s1;
	slsfr_pkg::bundle_t bundle;
	logic               valid_s1;
	logic               load_ok;
	logic               advance;

	assign advance = valid_s1 && load_ok;

	slsfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slsfr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	slsfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.bundle  (bundle)
	);

	slsfr_out_ser u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.bundle   (bundle),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### dv/sensor_link_sync_and_frame_receiver_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor link receiver checker
// Watches the config, input and result channels of the sensor link receiver.
// Each accepted input beat is run through a local model of the link (start-up
// commands, flush, sync hunt with resend and timeout, word and frame packing,
// stop). The expected result beats are queued, and each accepted result beat
// is compared field by field with the oldest one. Errors are counted.
// ----------------------------------------------------------------------------
module sensor_link_sync_and_frame_receiver_unit_checker
	import slsfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           error_count,
	output int           events_due
);

	localparam logic [79:0] SYNC_TEXT = "#SYNCH00\r\n";

	typedef struct packed {
		logic [1:0]  event_res;
		logic [1:0]  command;
		logic [31:0] yaw_bits;
		logic [31:0] pitch_bits;
		logic [31:0] roll_bits;
		logic        last;
	} link_event_t;

	link_event_t due_q[$];
	link_event_t batch[3];
	int          batch_n;
	link_event_t want;

	logic [15:0] timeout_ms;
	logic [15:0] resend_ms;
	logic [15:0] settle_ms;

	phase_t      link_phase;
	logic [3:0]  tok_idx;
	logic        tok_bad;
	logic [1:0]  byte_cnt;
	logic [1:0]  word_cnt;
	logic [31:0] word_build;
	logic [31:0] yaw_pitch_held[2];
	logic [15:0] since_start;
	logic [15:0] since_req;
	logic [15:0] settle_left;

	task automatic queue_event(input logic [1:0] ev, input logic [1:0] cmd,
			input logic [31:0] y, input logic [31:0] p, input logic [31:0] r);
		batch[batch_n].event_res = ev;
		batch[batch_n].command = cmd;
		batch[batch_n].yaw_bits = y;
		batch[batch_n].pitch_bits = p;
		batch[batch_n].roll_bits = r;
		batch[batch_n].last = 1'b0;
		batch_n++;
	endtask

	task automatic begin_hunt();
		queue_event(EV_CMD, CMD_SYNC, '0, '0, '0);
		settle_left = settle_ms;
		since_start = '0;
		since_req = '0;
		tok_idx = '0;
		tok_bad = 1'b0;
		link_phase = PH_HUNT;
	endtask

	task automatic predict_item(input logic [1:0] mode, input logic [7:0] rx);
		int i;
		batch_n = 0;
		case (mode)
			MODE_BYTE: begin
				case (link_phase)
					PH_WAIT: begin
						queue_event(EV_CMD, CMD_CONT, '0, '0, '0);
						queue_event(EV_CMD, CMD_BINARY, '0, '0, '0);
						if (rx == NEWLINE_CHAR)
							begin_hunt();
						else
							link_phase = PH_FLUSH;
					end
					PH_FLUSH: begin
						if (rx == NEWLINE_CHAR)
							begin_hunt();
					end
					PH_HUNT: begin
						if (tok_idx == 0) begin
							if (rx == HASH_CHAR) begin
								tok_idx = 4'd1;
								tok_bad = 1'b0;
							end
						end else begin
							if (rx != SYNC_TEXT[79 - 8 * tok_idx -: 8])
								tok_bad = 1'b1;
							tok_idx = tok_idx + 4'd1;
							if (tok_idx >= SYNC_TOKEN_LEN) begin
								if (!tok_bad) begin
									queue_event(EV_SYNC_OK, '0, '0, '0, '0);
									queue_event(EV_CMD, CMD_BINARY, '0, '0, '0);
									byte_cnt = '0;
									word_cnt = '0;
									word_build = '0;
									link_phase = PH_STREAM;
								end
								tok_idx = '0;
								tok_bad = 1'b0;
							end
						end
					end
					PH_STREAM: begin
						word_build[8 * byte_cnt +: 8] = rx;
						if (byte_cnt == 2'd3) begin
							byte_cnt = '0;
							if (word_cnt < 2'd2) begin
								yaw_pitch_held[word_cnt] = word_build;
								word_cnt = word_cnt + 2'd1;
							end else begin
								queue_event(EV_FRAME, '0, yaw_pitch_held[0],
									yaw_pitch_held[1], word_build);
								word_cnt = '0;
							end
							word_build = '0;
						end else begin
							byte_cnt = byte_cnt + 2'd1;
						end
					end
					default: ;
				endcase
			end
			MODE_TICK: begin
				if (link_phase == PH_HUNT && tok_idx == 0) begin
					if (settle_left != 0) begin
						settle_left = settle_left - 16'd1;
					end else begin
						if (since_req >= resend_ms) begin
							queue_event(EV_CMD, CMD_SYNC, '0, '0, '0);
							since_req = '0;
						end else begin
							since_req = since_req + 16'd1;
						end
						if (since_start >= timeout_ms) begin
							queue_event(EV_SYNC_FAIL, '0, '0, '0, '0);
							link_phase = PH_FAILED;
						end else begin
							since_start = since_start + 16'd1;
						end
					end
				end
			end
			MODE_STOP: begin
				if (link_phase == PH_STREAM) begin
					queue_event(EV_CMD, CMD_TEXT, '0, '0, '0);
					link_phase = PH_STOPPED;
				end
			end
			default: ;
		endcase
		for (i = 0; i < batch_n; i++) begin
			batch[i].last = (i == batch_n - 1);
			due_q.push_back(batch[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ms = 16'd1000;
			resend_ms = 16'd200;
			settle_ms = 16'd200;
			link_phase = PH_WAIT;
			tok_idx = '0;
			tok_bad = 1'b0;
			byte_cnt = '0;
			word_cnt = '0;
			word_build = '0;
			yaw_pitch_held[0] = '0;
			yaw_pitch_held[1] = '0;
			since_start = '0;
			since_req = '0;
			settle_left = '0;
			due_q.delete();
			error_count = 0;
			events_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: result beat with none expected: ev=%0d tdata=%h last=%b",
							$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = due_q.pop_front();
					if (m_tuser !== want.event_res || m_tdata[1:0] !== want.command ||
							m_tdata[33:2] !== want.yaw_bits ||
							m_tdata[65:34] !== want.pitch_bits ||
							m_tdata[97:66] !== want.roll_bits ||
							m_tdata[103:98] !== 6'd0 || m_tlast !== want.last) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected ev=%0d cmd=%0d yaw=%h pitch=%h roll=%h last=%b pad=00",
								want.event_res, want.command, want.yaw_bits,
								want.pitch_bits, want.roll_bits, want.last);
							$display("  actual   ev=%0d cmd=%0d yaw=%h pitch=%h roll=%h last=%b pad=%h",
								m_tuser, m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
								m_tdata[97:66], m_tlast, m_tdata[103:98]);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_ms = cfg_data;
					REG_RESEND:  resend_ms = cfg_data;
					REG_SETTLE:  settle_ms = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata);
			events_due = due_q.size();
		end
	end

endmodule

### dv/sensor_link_sync_and_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor link receiver testbench
// Drives the sensor link receiver through one whole link session: ignored
// beats before start-up, a random flush, a sync hunt with resends and broken
// tokens, sync, then a long stream of random bytes packed into frames, ended
// by a host stop. Register settings change between phases while the block is
// idle, and both sides idle at random. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module sensor_link_sync_and_frame_receiver_unit_tb;
	import slsfr_pkg::*;

	localparam logic [1:0]  MODE_RESERVED = 2'd3;
	localparam logic [79:0] SYNC_TEXT = "#SYNCH00\r\n";
	localparam logic [95:0] FRAME_BYTES = 96'hFFFFFFFF_00000000_01807FFE;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	int error_count;
	int events_due;
	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;

	sensor_link_sync_and_frame_receiver_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sensor_link_sync_and_frame_receiver_unit_checker link_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.error_count (error_count),
		.events_due  (events_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#3_000_000;
		$display("** sensor_link_sync_and_frame_receiver_unit: FAILED **");
		$finish;
	end

	task automatic send_beat(input logic [1:0] mode, input logic [7:0] rx);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= rx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// block quiet: no result owed and the pipeline emptied
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (events_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic pick_profile(input int unsigned p);
		case (p % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 84; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 84; end
			default: begin idle_pct = 17; stall_pct = 17; end
		endcase
	endtask

	function automatic logic [15:0] cfg_pick();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return $urandom_range(65535);
		endcase
	endfunction

	initial begin
		int unsigned sel, pos, k, ph, stop_at;
		logic [7:0] b;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_RESEND, 16'd2);
		write_reg(REG_SETTLE, 16'd2);

		// nothing happens before the first byte
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_STOP, 8'hFF);
		send_beat(MODE_RESERVED, 8'h55);
		if ($urandom_range(1) == 0) begin
			send_beat(MODE_BYTE, NEWLINE_CHAR);
		end else begin
			b = $urandom_range(255);
			send_beat(MODE_BYTE, (b == NEWLINE_CHAR) ? 8'hFF : b);
			send_beat(MODE_BYTE, 8'h00);
			send_beat(MODE_BYTE, 8'hFF);
			send_beat(MODE_BYTE, HASH_CHAR);
			send_beat(MODE_TICK, 8'h00);
			send_beat(MODE_STOP, 8'h00);
			send_beat(MODE_BYTE, NEWLINE_CHAR);
		end

		// two settle ticks, resend on the third counting tick
		repeat (5) send_beat(MODE_TICK, $urandom_range(255));
		send_beat(MODE_STOP, 8'h00);
		// token with a tick inside and a wrong second byte
		send_beat(MODE_BYTE, HASH_CHAR);
		send_beat(MODE_TICK, 8'h00);
		for (k = 1; k < SYNC_TOKEN_LEN; k++)
			send_beat(MODE_BYTE, (k == 1) ? 8'h73 : SYNC_TEXT[79 - 8 * k -: 8]);

		for (ph = 0; ph < 3; ph++) begin
			wait_drained();
			write_reg(REG_RESEND, (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'd1);
			write_reg(REG_SETTLE, (ph == 0) ? 16'hFFFF : cfg_pick());
			pick_profile(ph + 1);
			stop_at = items_sent + 40;
			while (items_sent < stop_at) begin
				sel = $urandom_range(99);
				if (sel < 35) begin
					send_beat(MODE_TICK, $urandom_range(255));
				end else if (sel < 50) begin
					send_beat(MODE_BYTE, $urandom_range(255));
				end else if (sel < 55) begin
					send_beat((sel < 53) ? MODE_STOP : MODE_RESERVED, $urandom_range(255));
				end else begin
					pos = $urandom_range(SYNC_TOKEN_LEN - 1, 1);
					send_beat(MODE_BYTE, HASH_CHAR);
					for (k = 1; k < SYNC_TOKEN_LEN; k++) begin
						if ($urandom_range(3) == 0)
							send_beat(MODE_TICK, $urandom_range(255));
						b = SYNC_TEXT[79 - 8 * k -: 8];
						if (k == pos)
							b = b ^ $urandom_range(255, 1);
						send_beat(MODE_BYTE, b);
					end
				end
			end
		end

		// nine plain bytes end any token in progress, then the real one
		repeat (9) send_beat(MODE_BYTE, 8'h00);
		for (k = 0; k < SYNC_TOKEN_LEN; k++)
			send_beat(MODE_BYTE, SYNC_TEXT[79 - 8 * k -: 8]);

		wait_drained();
		write_reg(REG_TIMEOUT, 16'd0);
		write_reg(REG_RESEND, 16'hFFFF);
		write_reg(REG_SETTLE, 16'd0);
		pick_profile(0);
		send_beat(MODE_TICK, 8'hA5);
		for (k = 0; k < 12; k++)
			send_beat(MODE_BYTE, FRAME_BYTES[95 - 8 * k -: 8]);

		for (ph = 0; ph < 5; ph++) begin
			wait_drained();
			write_reg(REG_TIMEOUT, cfg_pick());
			write_reg(REG_RESEND, cfg_pick());
			write_reg(REG_SETTLE, cfg_pick());
			pick_profile(ph);
			stop_at = items_sent + 44;
			while (items_sent < stop_at) begin
				sel = $urandom_range(99);
				if (sel < 85)
					send_beat(MODE_BYTE, $urandom_range(255));
				else if (sel < 93)
					send_beat(MODE_TICK, $urandom_range(255));
				else
					send_beat(MODE_RESERVED, $urandom_range(255));
			end
		end

		send_beat(MODE_STOP, $urandom_range(255));
		send_beat(MODE_BYTE, $urandom_range(255));
		send_beat(MODE_TICK, $urandom_range(255));
		send_beat(MODE_STOP, $urandom_range(255));
		wait_drained();

		if (error_count == 0 && events_due == 0)
			$display("** sensor_link_sync_and_frame_receiver_unit: PASSED **");
		else
			$display("** sensor_link_sync_and_frame_receiver_unit: FAILED **");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/slsfr_pkg.sv
sv/slsfr_cfg_regs.sv
sv/slsfr_in_reg.sv
sv/slsfr_core.sv
sv/slsfr_out_ser.sv
sv/sensor_link_sync_and_frame_receiver_unit.sv
dv/sensor_link_sync_and_frame_receiver_unit_checker.sv
dv/sensor_link_sync_and_frame_receiver_unit_tb.sv
